// File: hdl/mandelbrot_escape_time_pixel_core_defines.svh
// Assertion macros shared by the escape-time pixel core checker.
// No dependencies; take in with `include before the first use.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define MBET_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MBET_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mbet_pkg.sv
// Package for the escape-time pixel core: widths, reset values, codes,
// the microcode word and its program, and saturation helpers. No dependencies.
package mbet_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;

    // Register and field widths
    localparam int LEFT_W  = 32;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 16;
    localparam int LIM_W   = 35;
    localparam int CFG_W   = 35;
    localparam int CFG_IDX_W = 3;
    localparam int COL_W   = 12;
    localparam int GRAY_W  = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Datapath widths
    localparam int C_W    = FRAC_BITS + 4;
    localparam int Z_W    = FRAC_BITS + 8;
    localparam int SQ_W   = Z_W - 1;
    localparam int HALF_W = (Z_W + 1) / 2;
    localparam int A_W    = (Z_W > STEP_W) ? Z_W : STEP_W;
    localparam int PROD_W = A_W + HALF_W;
    localparam int ACC_W  = A_W + 2 * HALF_W;
    localparam int M_W    = ACC_W - FRAC_BITS;
    localparam int RI_W   = M_W + 1;
    localparam int WIDE_W = PROD_W + 2;
    localparam int DIV_W  = ITER_W + GRAY_W;
    localparam int K_W    = $clog2(GRAY_W);
    localparam int PC_W   = 5;

    // Reset values of the configuration registers
    localparam logic signed [LEFT_W-1:0] LEFT_RE_RST = -LEFT_W'(32'sd1073741824);
    localparam logic signed [LEFT_W-1:0] TOP_IM_RST  = -LEFT_W'(32'sd805306368);
    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(4473924);
    localparam logic [ITER_W-1:0] ITER_RST = ITER_W'(200);
    localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(64'd1073741824);

    localparam logic [GRAY_W-1:0] GRAY_FULL   = GRAY_W'(255);
    localparam logic [GRAY_W-1:0] GRAY_INSIDE = GRAY_W'(200);

    localparam logic [M_W:0] SQ_MAX = (M_W + 1)'((64'd1 << SQ_W) - 64'd1);

    localparam logic signed [WIDE_W-1:0] ZW_HI = WIDE_W'((64'sd1 <<< (Z_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] ZW_LO = -ZW_HI - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] CW_HI = WIDE_W'((64'sd1 <<< (C_W - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] CW_LO = -CW_HI - WIDE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_RE = 3'd0,
        CFG_TOP_IM  = 3'd1,
        CFG_STEP    = 3'd2,
        CFG_MAX_ITER = 3'd3,
        CFG_ESC_LIM = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {MA_STEP, MA_ZR, MA_ZI} t_mula;
    typedef enum logic [1:0] {MB_COL, MB_ROW, MB_ZR, MB_ZI} t_mulb;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADDHI} t_acc;
    typedef enum logic [3:0] {
        OP_NONE, OP_INIT, OP_CRE, OP_CIM, OP_RR, OP_II,
        OP_RI_ZR, OP_ZI_N, OP_DIV_INIT, OP_DIV_STEP
    } t_op;
    typedef enum logic [2:0] {CD_NEXT, CD_ALWAYS, CD_ITER_DONE, CD_ESC, CD_K_NZ} t_cond;

    typedef struct packed {
        logic            in_rdy;
        logic            out_wr;
        logic            out_esc;
        t_mula           mul_a;
        t_mulb           mul_b;
        logic            mul_hi;
        t_acc            acc;
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic iter_done;
        logic esc;
        logic k_nz;
        logic out_free;
    } t_status;

    // Program addresses
    localparam logic [PC_W-1:0] ST_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] ST_ITER     = PC_W'(4);
    localparam logic [PC_W-1:0] ST_FIN_NE   = PC_W'(13);
    localparam logic [PC_W-1:0] ST_DIV_INIT = PC_W'(14);
    localparam logic [PC_W-1:0] ST_DIV_STEP = PC_W'(15);
    localparam logic [PC_W-1:0] ST_FIN_ESC  = PC_W'(16);

    // Microcode ROM. Products run as two 18-bit passes, overlapped with
    // the accumulation of the previous pass.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            ST_IDLE: begin
                w.in_rdy = 1'b1;
            end
            PC_W'(1): begin
                w.mul_a = MA_STEP; w.mul_b = MB_COL; w.op = OP_INIT;
            end
            PC_W'(2): begin
                w.mul_a = MA_STEP; w.mul_b = MB_ROW; w.op = OP_CRE;
            end
            PC_W'(3): begin
                w.op = OP_CIM;
            end
            ST_ITER: begin
                w.mul_a = MA_ZR; w.mul_b = MB_ZR;
                w.cond = CD_ITER_DONE; w.target = ST_FIN_NE;
            end
            PC_W'(5): begin
                w.mul_a = MA_ZR; w.mul_b = MB_ZR; w.mul_hi = 1'b1; w.acc = ACC_LOAD;
            end
            PC_W'(6): begin
                w.mul_a = MA_ZI; w.mul_b = MB_ZI; w.acc = ACC_ADDHI;
            end
            PC_W'(7): begin
                w.mul_a = MA_ZI; w.mul_b = MB_ZI; w.mul_hi = 1'b1; w.acc = ACC_LOAD;
                w.op = OP_RR;
            end
            PC_W'(8): begin
                w.mul_a = MA_ZR; w.mul_b = MB_ZI; w.acc = ACC_ADDHI;
            end
            PC_W'(9): begin
                w.mul_a = MA_ZR; w.mul_b = MB_ZI; w.mul_hi = 1'b1; w.acc = ACC_LOAD;
                w.op = OP_II;
            end
            PC_W'(10): begin
                w.acc = ACC_ADDHI; w.cond = CD_ESC; w.target = ST_DIV_INIT;
            end
            PC_W'(11): begin
                w.op = OP_RI_ZR;
            end
            PC_W'(12): begin
                w.op = OP_ZI_N; w.cond = CD_ALWAYS; w.target = ST_ITER;
            end
            ST_FIN_NE: begin
                w.out_wr = 1'b1; w.cond = CD_ALWAYS; w.target = ST_IDLE;
            end
            ST_DIV_INIT: begin
                w.op = OP_DIV_INIT;
            end
            ST_DIV_STEP: begin
                w.op = OP_DIV_STEP; w.cond = CD_K_NZ; w.target = ST_DIV_STEP;
            end
            ST_FIN_ESC: begin
                w.out_wr = 1'b1; w.out_esc = 1'b1; w.cond = CD_ALWAYS; w.target = ST_IDLE;
            end
            default: begin
                w.cond = CD_ALWAYS; w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > ZW_HI) r = ZW_HI;
        else if (v < ZW_LO) r = ZW_LO;
        return r[Z_W-1:0];
    endfunction

    function automatic logic signed [C_W-1:0] sat_c(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > CW_HI) r = CW_HI;
        else if (v < CW_LO) r = CW_LO;
        return r[C_W-1:0];
    endfunction

    function automatic logic [Z_W-1:0] zmag(input logic signed [Z_W-1:0] v);
        return v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
    endfunction

endpackage

// File: hdl/mbet_seq.sv
// Microcode sequencer: step counter, program ROM from mbet_pkg and jump logic.
// Depends on mbet_pkg.
module mbet_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  mbet_pkg::t_status i_status,
    output mbet_pkg::t_uword o_uw,
    output logic             o_step_en
);
    import mbet_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          uw;
    logic            stall;
    logic            take;

    assign uw        = ucode(r_pc);
    assign o_uw      = uw;
    assign o_step_en = !stall;

    always_comb begin
        // hold on an input step with no beat, or an output step with a full register
        stall = (uw.in_rdy && !i_in_valid) || (uw.out_wr && !i_status.out_free);
        unique case (uw.cond)
            CD_NEXT:      take = 1'b0;
            CD_ALWAYS:    take = 1'b1;
            CD_ITER_DONE: take = i_status.iter_done;
            CD_ESC:       take = i_status.esc;
            CD_K_NZ:      take = i_status.k_nz;
            default:      take = 1'b0;
        endcase
        n_pc = r_pc;
        if (!stall) begin
            n_pc = take ? uw.target : r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hdl/mbet_dp.sv
// Datapath: configuration registers, shared 36x18 multiplier with accumulator,
// z update, restoring divider for the gray level and the output register.
// Depends on mbet_pkg; driven by mbet_seq.
module mbet_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mbet_pkg::t_uword                 i_uw,
    input  logic                             i_en,
    input  logic                             i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbet_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [mbet_pkg::COL_W-1:0]       i_column,
    input  logic [mbet_pkg::COL_W-1:0]       i_row,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_escaped,
    output logic [mbet_pkg::ITER_W-1:0]      o_iterations,
    output logic [mbet_pkg::GRAY_W-1:0]      o_gray_level,
    output mbet_pkg::t_status                o_status
);
    import mbet_pkg::*;

    // configuration
    logic signed [LEFT_W-1:0] r_left_re, r_top_im;
    logic [STEP_W-1:0]        r_step;
    logic [ITER_W-1:0]        r_max_iter;
    logic [LIM_W-1:0]         r_lim;

    // working registers
    logic [COORD_BITS-1:0]    r_col, r_row;
    logic signed [C_W-1:0]    r_cr, r_ci;
    logic signed [Z_W-1:0]    r_zr, r_zi;
    logic [PROD_W-1:0]        r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic [M_W-1:0]           r_rr, r_ii;
    logic signed [RI_W-1:0]   r_ri;
    logic [ITER_W-1:0]        r_n;
    logic [DIV_W-1:0]         r_rem;
    logic [GRAY_W-1:0]        r_q;
    logic [K_W-1:0]           r_k;

    logic                     r_out_valid;
    logic                     r_out_esc;
    logic [ITER_W-1:0]        r_out_iter;
    logic [GRAY_W-1:0]        r_out_gray;

    logic [A_W-1:0]           a_mag;
    logic [2*HALF_W-1:0]      b_ext;
    logic [HALF_W-1:0]        b_half;
    logic [PROD_W-1:0]        mul_out;
    logic [M_W-1:0]           m_val;
    logic [M_W:0]             mag_sum;
    logic [M_W:0]             mag_sat;
    logic signed [RI_W-1:0]   ri_val;
    logic signed [WIDE_W-1:0] cre_sum, cim_sum, zr_sum, zi_sum;
    logic [DIV_W-1:0]         d_sh;
    logic                     rem_ge;
    logic                     out_free;

    always_comb begin
        unique case (i_uw.mul_a)
            MA_STEP: a_mag = A_W'(r_step);
            MA_ZR:   a_mag = A_W'(zmag(r_zr));
            MA_ZI:   a_mag = A_W'(zmag(r_zi));
            default: a_mag = '0;
        endcase
        unique case (i_uw.mul_b)
            MB_COL:  b_ext = (2*HALF_W)'(r_col);
            MB_ROW:  b_ext = (2*HALF_W)'(r_row);
            MB_ZR:   b_ext = (2*HALF_W)'(zmag(r_zr));
            MB_ZI:   b_ext = (2*HALF_W)'(zmag(r_zi));
            default: b_ext = '0;
        endcase
        b_half = i_uw.mul_hi ? b_ext[2*HALF_W-1:HALF_W] : b_ext[HALF_W-1:0];
    end

    assign mul_out = PROD_W'(a_mag) * PROD_W'(b_half);
    assign m_val   = r_acc[ACC_W-1:FRAC_BITS];

    // |z|^2 saturates at the Q8 maximum before the compare
    assign mag_sum = {1'b0, r_rr} + {1'b0, r_ii};
    assign mag_sat = (mag_sum > SQ_MAX) ? SQ_MAX : mag_sum;

    assign ri_val = (r_zr[Z_W-1] ^ r_zi[Z_W-1]) ? -$signed(RI_W'(m_val))
                                                 : $signed(RI_W'(m_val));

    assign cre_sum = WIDE_W'(r_left_re) + $signed(WIDE_W'(r_prod));
    assign cim_sum = WIDE_W'(r_top_im) + $signed(WIDE_W'(r_prod));
    assign zr_sum  = $signed(WIDE_W'(r_rr)) - $signed(WIDE_W'(r_ii)) + WIDE_W'(r_cr);
    assign zi_sum  = (WIDE_W'(r_ri) <<< 1) + WIDE_W'(r_ci);

    assign d_sh   = DIV_W'(r_max_iter) << r_k;
    assign rem_ge = r_rem >= d_sh;

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.iter_done = r_n >= r_max_iter;
    assign o_status.esc       = mag_sat > (M_W + 1)'(r_lim);
    assign o_status.k_nz      = r_k != '0;
    assign o_status.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_re  <= LEFT_RE_RST;
            r_top_im   <= TOP_IM_RST;
            r_step     <= STEP_RST;
            r_max_iter <= ITER_RST;
            r_lim      <= LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_RE:  r_left_re  <= i_cfg_data[LEFT_W-1:0];
                CFG_TOP_IM:   r_top_im   <= i_cfg_data[LEFT_W-1:0];
                CFG_STEP:     r_step     <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                CFG_ESC_LIM:  r_lim      <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mul_out;
            if (i_uw.in_rdy) begin
                r_col <= i_column[COORD_BITS-1:0];
                r_row <= i_row[COORD_BITS-1:0];
            end
            unique case (i_uw.acc)
                ACC_HOLD:  ;
                ACC_LOAD:  r_acc <= ACC_W'(r_prod);
                ACC_ADDHI: r_acc <= r_acc + (ACC_W'(r_prod) << HALF_W);
                default:   ;
            endcase
            unique case (i_uw.op)
                OP_NONE: ;
                OP_INIT: begin
                    r_zr <= '0;
                    r_zi <= '0;
                    r_n  <= '0;
                end
                OP_CRE:   r_cr <= sat_c(cre_sum);
                OP_CIM:   r_ci <= sat_c(cim_sum);
                OP_RR:    r_rr <= m_val;
                OP_II:    r_ii <= m_val;
                OP_RI_ZR: begin
                    r_ri <= ri_val;
                    r_zr <= sat_z(zr_sum);
                end
                OP_ZI_N: begin
                    r_zi <= sat_z(zi_sum);
                    r_n  <= r_n + 1'b1;
                end
                OP_DIV_INIT: begin
                    // n*255 as (n << 8) - n
                    r_rem <= (DIV_W'(r_n) << GRAY_W) - DIV_W'(r_n);
                    r_q   <= '0;
                    r_k   <= K_W'(GRAY_W - 1);
                end
                OP_DIV_STEP: begin
                    if (rem_ge) begin
                        r_rem    <= r_rem - d_sh;
                        r_q[r_k] <= 1'b1;
                    end
                    r_k <= r_k - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en && i_uw.out_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_uw.out_wr) begin
            r_out_esc  <= i_uw.out_esc;
            r_out_iter <= r_n;
            r_out_gray <= i_uw.out_esc ? r_q : GRAY_INSIDE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_escaped    = r_out_esc;
    assign o_iterations = r_out_iter;
    assign o_gray_level = r_out_gray;

endmodule

// File: hdl/mandelbrot_escape_time_pixel_core.sv
// Top level of the escape-time pixel core: stream ports, configuration port.
// Depends on mbet_pkg, mbet_seq and mbet_dp.
//
// Usage: write the five view registers over the cfg port while idle, then
// send one beat per pixel on the slave stream (column, row). Each beat gives
// one result beat on the master stream: escaped flag, iteration count and
// gray level. A microcoded sequencer drives one 36x18 multiplier; every
// product of z takes two passes, three products per iteration. A point
// that escapes also runs the 8-step gray-level divider before its result
// is written. The next input beat can be taken in the cycle after the
// result is loaded; a result waiting in the output register does not block
// the next pixel. If the sink stalls, the core holds its result and waits
// before writing the next one.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_m_tvalid and restores the default view: -4.0 - 3.0i, 200 iterations.
module mandelbrot_escape_time_pixel_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [mbet_pkg::S_TDATA_W-1:0]      i_s_tdata,   // column[11:0], row[23:12]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [mbet_pkg::M_TDATA_W-1:0]      o_m_tdata,   // escaped[0], iterations[16:1], gray_level[24:17], zero pad
    input  logic                                i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbet_pkg::CFG_W-1:0]          i_cfg_data
);
    import mbet_pkg::*;

    t_uword            uw;
    t_status           status;
    logic              step_en;
    logic              out_esc;
    logic [ITER_W-1:0] out_iter;
    logic [GRAY_W-1:0] out_gray;

    mbet_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (status),
        .o_uw       (uw),
        .o_step_en  (step_en)
    );

    mbet_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uw         (uw),
        .i_en         (step_en),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_column     (i_s_tdata[COL_W-1:0]),
        .i_row        (i_s_tdata[2*COL_W-1:COL_W]),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_escaped    (out_esc),
        .o_iterations (out_iter),
        .o_gray_level (out_gray),
        .o_status     (status)
    );

    assign o_s_tready = uw.in_rdy;
    assign o_m_tdata  = {(M_TDATA_W - 1 - ITER_W - GRAY_W)'(0), out_gray, out_iter, out_esc};

endmodule

// File: hdl/mbet_chk.sv
// Port-level checker for the escape-time pixel core, bound to the top level.
// Depends on mbet_pkg and mandelbrot_escape_time_pixel_core_defines.svh.
`include "mandelbrot_escape_time_pixel_core_defines.svh"

module mbet_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           i_s_tready,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [mbet_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import mbet_pkg::*;

    `MBET_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_m_tvalid && i_s_tready, "reset must leave the core idle with no result")

    `MBET_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "stalled result beat changed")

    `MBET_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "input taken while a pixel is in work")

    `MBET_ASSERT(a_inside_gray, i_clk, i_rst_n, i_m_tvalid && !i_m_tdata[0] |-> i_m_tdata[24:17] == GRAY_INSIDE, "inside point without its fixed gray level")

    `MBET_ASSERT(a_escaped_range, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[0] |-> i_m_tdata[24:17] != GRAY_FULL && i_m_tdata[16:1] != '0, "escaped point with impossible count or gray level")

endmodule

bind mandelbrot_escape_time_pixel_core mbet_chk u_mbet_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the escape-time pixel core: directed and random pixels checked
// against a bit-exact escape-time predictor kept in a small scoreboard class.
// Depends on mbet_pkg and mandelbrot_escape_time_pixel_core.
module tb_top;
    import mbet_pkg::*;

    localparam int      CLK_PERIOD    = 20;
    localparam longint  RUN_LIMIT_NS  = 100_000_000;
    localparam int      RANDOM_PIXELS = 1450;
    localparam int      HOLD_CYCLES   = 400;
    localparam longint  Q1            = longint'(1) <<< FRAC_BITS;
    localparam logic [127:0]     PROD_CAP  = 128'd1 << 61;
    localparam logic [LIM_W-1:0] LIM_NEVER = {LIM_W{1'b1}};

    typedef struct packed {
        logic              escaped;
        logic [ITER_W-1:0] iterations;
        logic [GRAY_W-1:0] gray_level;
    } t_pixel_result;

    typedef struct packed {
        logic signed [LEFT_W-1:0] left_re;
        logic signed [LEFT_W-1:0] top_im;
        logic [STEP_W-1:0]        step;
        logic [ITER_W-1:0]        max_iter;
        logic [LIM_W-1:0]         esc_lim;
    } t_view_regs;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        t_pixel_result    res;
    } t_awaited_pixel;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} t_sink_mode;

    class t_escape_scoreboard;
        t_view_regs     view = '{LEFT_RE_RST, TOP_IM_RST, STEP_RST, ITER_RST, LIM_RST};
        t_awaited_pixel awaited[$];
        int             mismatches   = 0;
        int             pixels_seen  = 0;
        int             escaped_seen = 0;
        int             inside_seen  = 0;

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_LEFT_RE:  view.left_re  = data[LEFT_W-1:0];
                CFG_TOP_IM:   view.top_im   = data[LEFT_W-1:0];
                CFG_STEP:     view.step     = data[STEP_W-1:0];
                CFG_MAX_ITER: view.max_iter = data[ITER_W-1:0];
                CFG_ESC_LIM:  view.esc_lim  = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Q.F product on magnitudes, truncated, capped, then signed
        function longint qmul(longint a, longint b);
            logic         neg;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [127:0] mag;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? 64'(-a) : 64'(a);
            ub  = (b < 0) ? 64'(-b) : 64'(b);
            mag = (128'(ua) * 128'(ub)) >> FRAC_BITS;
            if (mag > PROD_CAP) mag = PROD_CAP;
            return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        endfunction

        function longint clamp_to(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function t_pixel_result escape_time(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
            t_pixel_result r;
            longint        c_re, c_im, zr, zi, rr, ii, ri, mag, sq_max;
            int            n;
            bit            esc;
            c_re = clamp_to(longint'(view.left_re) + longint'(view.step) * longint'(col), C_W);
            c_im = clamp_to(longint'(view.top_im) + longint'(view.step) * longint'(row), C_W);
            sq_max = (longint'(1) <<< SQ_W) - 1;
            zr  = 0;
            zi  = 0;
            esc = 1'b0;
            for (n = 0; n < int'(view.max_iter); n++) begin
                rr  = qmul(zr, zr);
                ii  = qmul(zi, zi);
                mag = rr + ii;
                if (mag > sq_max) mag = sq_max;
                if (mag > longint'(view.esc_lim)) begin
                    esc = 1'b1;
                    break;
                end
                ri = qmul(zr, zi);
                zr = clamp_to(rr - ii + c_re, Z_W);
                zi = clamp_to(2 * ri + c_im, Z_W);
            end
            r.escaped    = esc;
            r.iterations = n[ITER_W-1:0];
            r.gray_level = esc ? GRAY_W'((n * int'(GRAY_FULL)) / int'(view.max_iter))
                               : GRAY_INSIDE;
            return r;
        endfunction

        function void note_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
            t_awaited_pixel a;
            a.col = col;
            a.row = row;
            a.res = escape_time(col, row);
            if (a.res.escaped) escaped_seen++;
            else inside_seen++;
            awaited.push_back(a);
        endfunction

        task check_result(logic [M_TDATA_W-1:0] tdata);
            t_pixel_result  got;
            t_awaited_pixel want;
            got.escaped    = tdata[0];
            got.iterations = tdata[ITER_W:1];
            got.gray_level = tdata[ITER_W+GRAY_W:ITER_W+1];
            if (awaited.size() == 0) begin
                report($sformatf("result beat 0x%08h with no pixel outstanding", tdata));
                return;
            end
            want = awaited.pop_front();
            pixels_seen++;
            if (got.escaped != want.res.escaped)
                report($sformatf("pixel (%0d,%0d) escaped %0b, want %0b",
                    want.col, want.row, got.escaped, want.res.escaped));
            if (got.iterations != want.res.iterations)
                report($sformatf("pixel (%0d,%0d) iterations %0d, want %0d",
                    want.col, want.row, got.iterations, want.res.iterations));
            if (got.gray_level != want.res.gray_level)
                report($sformatf("pixel (%0d,%0d) gray %0d, want %0d",
                    want.col, want.row, got.gray_level, want.res.gray_level));
        endtask
    endclass

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    t_escape_scoreboard sb;
    bit               hold_req   = 1'b0;
    int               burst_left = 0;
    int               pixels_sent = 0;
    int               views_set   = 0;

    mandelbrot_escape_time_pixel_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Sink: random stall modes, plus a long hold-off on request
    initial begin : sink_stall
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge i_clk); while (!s_tready);
        sb.note_pixel(col, row);
        pixels_sent++;
    endtask

    // Bursts of random length, random gaps between them
    task automatic pace_sender(input bit steady);
        int gap;
        if (steady) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 14);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Fill bits above the register width with noise half the time
    function automatic logic [CFG_W-1:0] pad_junk(input logic [CFG_W-1:0] v, input int w);
        logic [CFG_W-1:0] noise;
        noise = CFG_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0) return v;
        return v | (noise << w);
    endfunction

    task automatic set_view(input logic signed [LEFT_W-1:0] lft,
                            input logic signed [LEFT_W-1:0] top,
                            input logic [STEP_W-1:0]        step,
                            input logic [ITER_W-1:0]        iters,
                            input logic [LIM_W-1:0]         lim);
        write_reg(CFG_LEFT_RE,  pad_junk(CFG_W'(unsigned'(lft)), LEFT_W));
        write_reg(CFG_TOP_IM,   pad_junk(CFG_W'(unsigned'(top)), LEFT_W));
        write_reg(CFG_STEP,     pad_junk(CFG_W'(step), STEP_W));
        write_reg(CFG_MAX_ITER, pad_junk(CFG_W'(iters), ITER_W));
        write_reg(CFG_ESC_LIM,  CFG_W'(lim));
        views_set++;
    endtask

    initial begin : stimulus
        int                       phase, i, n_items, tail, random_sent;
        bit                       steady, wide, full;
        logic signed [LEFT_W-1:0] lft, top;
        logic [STEP_W-1:0]        step;
        logic [ITER_W-1:0]        iters;
        logic [LIM_W-1:0]         lim;
        logic [COL_W-1:0]         col, row;

        sb = new;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset view: corners, two points outside the set, saturated c
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(60, 45);
        send_pixel(30, 45);
        send_pixel(0, 4095);
        drain_results();

        // Unknown register indexes must leave the view alone
        for (int k = int'(CFG_ESC_LIM) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), '1);
        send_pixel(60, 45);
        drain_results();

        // Zero iteration limit
        set_view(0, 0, 0, 0, LIM_RST);
        send_pixel(123, 456);
        drain_results();

        // Largest iteration limit, far points that escape at once
        set_view(32'sh7fff_ffff, 0, 0, 16'hffff, LIM_RST);
        send_pixel(0, 0);
        drain_results();
        set_view(32'sh8000_0000, 32'sh8000_0000, 0, 16'hffff, LIM_RST);
        send_pixel(4095, 0);
        drain_results();

        // Limit equal to the saturated magnitude never fires; c and z saturate
        set_view(32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff, 12, LIM_NEVER);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        send_pixel(1, 0);
        drain_results();

        // Zero limit
        set_view(0, 0, 1, 10, '0);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        drain_results();

        // Single iteration on the reset view
        set_view(LEFT_RE_RST, TOP_IM_RST, STEP_RST, 1, LIM_RST);
        send_pixel(0, 0);
        send_pixel(60, 45);
        drain_results();

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            phase++;
            wide = ($urandom_range(0, 3) == 0);
            if (wide) begin
                lft  = $urandom;
                top  = $urandom;
                step = $urandom_range(0, 32'h7fff_ffff);
            end else begin
                lft  = LEFT_W'(-(5 * Q1 / 2) + longint'($urandom_range(0, 2 * Q1)));
                top  = LEFT_W'(-(3 * Q1 / 2) + longint'($urandom_range(0, 5 * Q1 / 4)));
                step = $urandom_range(Q1 / 128, Q1 / 16);
            end
            case ($urandom_range(0, 7))
                0:       iters = 1;
                6:       iters = $urandom_range(25, 64);
                default: iters = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 7))
                5:       lim = '0;
                6:       lim = LIM_NEVER;
                7:       lim = ($urandom_range(0, 1) == 1) ? LIM_W'({$urandom, $urandom})
                                                           : LIM_W'(64'd1 << 34);
                default: lim = LIM_RST;
            endcase
            steady  = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(60, 140);
            if (phase == 2) begin
                // short pixels, steady sender: fill the core while the sink holds off
                iters  = 2;
                steady = 1'b1;
            end else if (phase == 4) begin
                wide    = 1'b0;
                lft     = LEFT_RE_RST;
                top     = TOP_IM_RST;
                step    = STEP_RST;
                iters   = ITER_RST;
                lim     = LIM_RST;
                n_items = 20;
            end
            set_view(lft, top, step, iters, lim);
            for (i = 0; i < n_items && random_sent < RANDOM_PIXELS; i++) begin
                if (phase == 2 && i == 8) hold_req = 1'b1;
                if (phase == 3 && i == 40) drain_results();
                full = wide || ($urandom_range(0, 7) == 0);
                col  = full ? COL_W'($urandom) : COL_W'($urandom_range(0, 63));
                row  = full ? COL_W'($urandom) : COL_W'($urandom_range(0, 63));
                send_pixel(col, row);
                random_sent++;
                pace_sender(steady);
            end
            drain_results();
        end

        tail = 9 * int'(sb.view.max_iter) + 25;
        if (tail > 2000) tail = 2000;
        repeat (tail) @(posedge i_clk);

        $display("Run covered %0d pixels over %0d view settings: %0d escaped, %0d inside.",
            pixels_sent, views_set, sb.escaped_seen, sb.inside_seen);
        $display("Results checked: %0d, mismatches: %0d.", sb.pixels_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: mandelbrot_escape_time_pixel_core.f
+incdir+hdl
hdl/mbet_pkg.sv
hdl/mbet_seq.sv
hdl/mbet_dp.sv
hdl/mandelbrot_escape_time_pixel_core.sv
hdl/mbet_chk.sv
verif/tb_top.sv
